@@ rtl/strided_tensor_address_gen_macros.svh @@
// Assertion macros shared by the strided tensor address generator.
`ifndef STRIDED_TENSOR_ADDRESS_GEN_MACROS_SVH
`define STRIDED_TENSOR_ADDRESS_GEN_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define STAG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("address generator check failed");

// Condition must hold in the cycle after the trigger.
`define STAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("address generator check failed");

`endif

@@ rtl/stag_pkg.sv @@
// Shared widths, register codes and types of the strided tensor address generator.
`default_nettype none

package stag_pkg;

    localparam int unsigned IDX_W        = 32;
    localparam int unsigned SZ_W         = 16;
    localparam int unsigned STRIDE_W     = 32;
    localparam int unsigned PROD_W       = SZ_W + STRIDE_W;
    localparam int unsigned OFF_W        = 50;
    localparam int unsigned BYTE_W       = 53;
    localparam int unsigned REG_DIMS     = 4;
    localparam int unsigned SIZES_W      = REG_DIMS * SZ_W;
    localparam int unsigned CNT_W        = 3;
    localparam int unsigned ESL_W        = 2;
    localparam int unsigned CFG_DATA_W   = 64;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned DIV_BITS     = 4;
    localparam int unsigned DIV_STAGES   = IDX_W / DIV_BITS;
    localparam int unsigned DEF_MAX_DIMS = 4;

    localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE3   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ELEM_SIZE = 3'd6;

    localparam logic [ESL_W-1:0] ESL_RESET = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0] word;
        logic [SZ_W-1:0]  rem;
        logic [OFF_W-1:0] off;
    } t_item;

    typedef struct packed {
        logic [OFF_W-1:0]  elem_off;
        logic [BYTE_W-1:0] byte_off;
        logic              oor;
        logic              dense;
    } t_res;

    typedef struct packed {
        logic [CNT_W-1:0]                    dim_n;
        logic [SIZES_W-1:0]                  sizes;
        logic [REG_DIMS-1:0][STRIDE_W-1:0]   strides;
        logic [ESL_W-1:0]                    esl;
        logic                                dense;
        logic                                zero;
    } t_cfg;

endpackage

`default_nettype wire

@@ rtl/stag_cfg.sv @@
// Configuration registers with the derived dense-stride and zero-size flags.
`default_nettype none

module stag_cfg #(
    parameter int unsigned DIMS = stag_pkg::DEF_MAX_DIMS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [stag_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [stag_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output stag_pkg::t_cfg                        o_cfg
);

    logic [stag_pkg::CNT_W-1:0]                                 r_dim_count;
    logic [stag_pkg::SIZES_W-1:0]                               r_sizes;
    logic [stag_pkg::REG_DIMS-1:0][stag_pkg::STRIDE_W-1:0]      r_strides;
    logic [stag_pkg::ESL_W-1:0]                                 r_esl;
    logic [stag_pkg::SZ_W-1:0]                                  r_e2;
    logic [2*stag_pkg::SZ_W-1:0]                                r_e1;
    logic [stag_pkg::PROD_W-1:0]                                r_e0;
    logic                                                       r_dense;
    logic                                                       r_zero;
    logic [stag_pkg::CNT_W-1:0]                                 dim_n;
    logic [stag_pkg::REG_DIMS-1:0][stag_pkg::SZ_W-1:0]          sz_eff;
    logic [stag_pkg::REG_DIMS-1:0][stag_pkg::PROD_W-1:0]        expect_stride;
    logic                                                       n_dense;
    logic                                                       n_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count <= '0;
            r_sizes     <= '0;
            r_strides   <= '0;
            r_esl       <= stag_pkg::ESL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                stag_pkg::REG_DIM_COUNT: r_dim_count <= i_cfg_data[stag_pkg::CNT_W-1:0];
                stag_pkg::REG_DIM_SIZES: r_sizes <= i_cfg_data[stag_pkg::SIZES_W-1:0];
                stag_pkg::REG_STRIDE0:   r_strides[0] <= i_cfg_data[stag_pkg::STRIDE_W-1:0];
                stag_pkg::REG_STRIDE1:   r_strides[1] <= i_cfg_data[stag_pkg::STRIDE_W-1:0];
                stag_pkg::REG_STRIDE2:   r_strides[2] <= i_cfg_data[stag_pkg::STRIDE_W-1:0];
                stag_pkg::REG_STRIDE3:   r_strides[3] <= i_cfg_data[stag_pkg::STRIDE_W-1:0];
                stag_pkg::REG_ELEM_SIZE: r_esl <= i_cfg_data[stag_pkg::ESL_W-1:0];
                default: ;
            endcase
        end
    end

    assign dim_n = (r_dim_count > stag_pkg::CNT_W'(DIMS)) ? stag_pkg::CNT_W'(DIMS)
                                                           : r_dim_count;

    // Unused dimensions count as size one so the running products skip them.
    always_comb begin
        for (int d = 0; d < stag_pkg::REG_DIMS; d++) begin
            sz_eff[d] = (stag_pkg::CNT_W'(d) < dim_n) ? r_sizes[d*stag_pkg::SZ_W +: stag_pkg::SZ_W]
                                                      : stag_pkg::SZ_W'(1);
        end
    end

    // The expected strides are registered through r_e2, r_e1 and r_e0, and the flags after them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2    <= '0;
            r_e1    <= '0;
            r_e0    <= '0;
            r_dense <= 1'b1;
            r_zero  <= 1'b0;
        end else begin
            r_e2    <= sz_eff[3];
            r_e1    <= r_e2 * sz_eff[2];
            r_e0    <= r_e1 * sz_eff[1];
            r_dense <= n_dense;
            r_zero  <= n_zero;
        end
    end

    assign expect_stride[3] = stag_pkg::PROD_W'(1);
    assign expect_stride[2] = stag_pkg::PROD_W'(r_e2);
    assign expect_stride[1] = stag_pkg::PROD_W'(r_e1);
    assign expect_stride[0] = r_e0;

    always_comb begin
        n_dense = 1'b1;
        n_zero  = 1'b0;
        for (int d = 0; d < stag_pkg::REG_DIMS; d++) begin
            if (stag_pkg::CNT_W'(d) < dim_n) begin
                if (stag_pkg::PROD_W'(r_strides[d]) != expect_stride[d]) begin
                    n_dense = 1'b0;
                end
                if (sz_eff[d] == '0) begin
                    n_zero = 1'b1;
                end
            end
        end
    end

    assign o_cfg.dim_n   = dim_n;
    assign o_cfg.sizes   = r_sizes;
    assign o_cfg.strides = r_strides;
    assign o_cfg.esl     = r_esl;
    assign o_cfg.dense   = r_dense;
    assign o_cfg.zero    = r_zero;

endmodule

`default_nettype wire

@@ rtl/stag_div_stage.sv @@
// One registered step of the divider: several quotient bits of restoring division.
`default_nettype none

module stag_div_stage (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire stag_pkg::t_item             i_item,
    input  wire logic [stag_pkg::SZ_W-1:0]   i_divisor,
    output logic                             o_valid,
    output stag_pkg::t_item                  o_item
);

    logic                          r_valid;
    stag_pkg::t_item               r_item;
    stag_pkg::t_item               n_item;
    logic [stag_pkg::IDX_W-1:0]    word;
    logic [stag_pkg::SZ_W:0]       trial;
    logic [stag_pkg::SZ_W-1:0]     rem;

    // The quotient bits shift in at the bottom as the dividend shifts out at the top.
    always_comb begin
        word  = i_item.word;
        rem   = i_item.rem;
        trial = '0;
        for (int s = 0; s < stag_pkg::DIV_BITS; s++) begin
            trial = {rem, word[stag_pkg::IDX_W-1]};
            word  = {word[stag_pkg::IDX_W-2:0], 1'b0};
            if (trial >= {1'b0, i_divisor}) begin
                trial   = trial - {1'b0, i_divisor};
                word[0] = 1'b1;
            end
            rem = trial[stag_pkg::SZ_W-1:0];
        end
        n_item      = i_item;
        n_item.word = word;
        n_item.rem  = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ rtl/stag_dim_unit.sv @@
// One dimension: divide by its size, multiply the coordinate by its stride, accumulate.
`default_nettype none

module stag_dim_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_valid,
    input  wire stag_pkg::t_item                i_item,
    input  wire logic [stag_pkg::SZ_W-1:0]      i_divisor,
    input  wire logic [stag_pkg::STRIDE_W-1:0]  i_stride,
    output logic                                o_valid,
    output stag_pkg::t_item                     o_item
);

    logic                               div_valid [stag_pkg::DIV_STAGES+1];
    stag_pkg::t_item                    div_item  [stag_pkg::DIV_STAGES+1];
    logic                               r_m_valid;
    stag_pkg::t_item                    r_m_item;
    logic [stag_pkg::PROD_W-1:0]        r_prod;
    logic                               r_a_valid;
    stag_pkg::t_item                    r_a_item;

    assign div_valid[0] = i_valid;
    assign div_item[0]  = i_item;

    for (genvar g = 0; g < stag_pkg::DIV_STAGES; g++) begin : g_div
        stag_div_stage u_div (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (i_en),
            .i_valid   (div_valid[g]),
            .i_item    (div_item[g]),
            .i_divisor (i_divisor),
            .o_valid   (div_valid[g+1]),
            .o_item    (div_item[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_m_valid <= div_valid[stag_pkg::DIV_STAGES];
            r_a_valid <= r_m_valid;
        end
    end

    // The remainder is the coordinate; an unused dimension divides by one and adds nothing.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_item      <= div_item[stag_pkg::DIV_STAGES];
            r_prod        <= div_item[stag_pkg::DIV_STAGES].rem * i_stride;
            r_a_item.word <= r_m_item.word;
            r_a_item.rem  <= '0;
            r_a_item.off  <= r_m_item.off + stag_pkg::OFF_W'(r_prod);
        end
    end

    assign o_valid = r_a_valid;
    assign o_item  = r_a_item;

endmodule

`default_nettype wire

@@ rtl/stag_out_buf.sv @@
// Two-entry result buffer that decouples the pipeline from the receiver's stall.
`default_nettype none

`include "strided_tensor_address_gen_macros.svh"

module stag_out_buf (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire stag_pkg::t_res  i_res,
    input  wire logic            i_stall,
    output logic                 o_ready,
    output logic                 o_valid,
    output stag_pkg::t_res       o_res
);

    logic [1:0]      r_cnt;
    stag_pkg::t_res  r_head;
    stag_pkg::t_res  r_tail;
    logic            pop;

    assign pop     = (r_cnt != 2'd0) && !i_stall;
    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_push && !pop) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (pop && !i_push) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_head <= (r_cnt == 2'd2) ? r_tail : i_res;
        end else if (i_push && r_cnt == 2'd0) begin
            r_head <= i_res;
        end
        if (i_push && ((r_cnt == 2'd1 && !pop) || r_cnt == 2'd2)) begin
            r_tail <= i_res;
        end
    end

    `STAG_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n, r_cnt == 2'd2, !i_push)

endmodule

`default_nettype wire

@@ rtl/strided_tensor_address_gen.sv @@
// Top level of the strided tensor address generator.
//
// Input channel: i_valid / o_stall carry one linear element index per beat.
// Output channel: o_valid / i_stall carry the element offset, the byte offset,
// the out-of-range flag and the dense-stride flag for each index, in order.
// Configuration: i_cfg_we writes i_cfg_data to the register picked by
// i_cfg_index; the user must make writes only while no beat is in flight,
// as the block itself does not enforce this. Throughput is one beat per
// cycle while o_stall is low. Each dimension passes through eight divider
// stages of four quotient bits, a multiply stage and an accumulate stage;
// the results then pass through the result buffer. Indexing runs from the
// last dimension down to dimension 0. The dense and zero-size flags are
// recomputed from the registers after a write, through registered stages.
// Reset clears the pipeline valid bits, the buffer and the registers
// (element size four bytes). When the receiver stalls, results gather in a
// two-entry buffer; once it is full o_stall rises and the whole pipeline
// holds, so no beat is lost or repeated.
`default_nettype none

`include "strided_tensor_address_gen_macros.svh"

module strided_tensor_address_gen #(
    parameter int unsigned MAX_DIMS = stag_pkg::DEF_MAX_DIMS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [stag_pkg::IDX_W-1:0]       i_linear_index,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [stag_pkg::OFF_W-1:0]            o_element_offset,
    output logic [stag_pkg::BYTE_W-1:0]           o_byte_offset,
    output logic                                  o_out_of_range,
    output logic                                  o_is_dense,
    input  wire logic                             i_cfg_we,
    input  wire logic [stag_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [stag_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int unsigned LP_DIMS = (MAX_DIMS < stag_pkg::REG_DIMS) ? MAX_DIMS
                                                                        : stag_pkg::REG_DIMS;

    stag_pkg::t_cfg   cfg;
    logic             en;
    logic             chain_valid [LP_DIMS+1];
    stag_pkg::t_item  chain_item  [LP_DIMS+1];
    stag_pkg::t_res   res;
    stag_pkg::t_res   out_res;
    logic             oor;

    stag_cfg #(
        .DIMS (LP_DIMS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign chain_valid[0]     = i_valid;
    assign chain_item[0].word = i_linear_index;
    assign chain_item[0].rem  = '0;
    assign chain_item[0].off  = '0;

    // Unit k handles dimension LP_DIMS-1-k, so the last dimension is split off first.
    for (genvar k = 0; k < LP_DIMS; k++) begin : g_dim
        localparam int unsigned LP_D = LP_DIMS - 1 - k;
        logic [stag_pkg::SZ_W-1:0] divisor;

        assign divisor = (stag_pkg::CNT_W'(LP_D) < cfg.dim_n)
                       ? cfg.sizes[LP_D*stag_pkg::SZ_W +: stag_pkg::SZ_W]
                       : stag_pkg::SZ_W'(1);

        stag_dim_unit u_dim (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (en),
            .i_valid   (chain_valid[k]),
            .i_item    (chain_item[k]),
            .i_divisor (divisor),
            .i_stride  (cfg.strides[LP_D]),
            .o_valid   (chain_valid[k+1]),
            .o_item    (chain_item[k+1])
        );
    end

    // A nonzero quotient left over means the index reached the element count.
    assign oor          = cfg.zero || (chain_item[LP_DIMS].word != '0);
    assign res.oor      = oor;
    assign res.dense    = cfg.dense;
    assign res.elem_off = oor ? '0 : chain_item[LP_DIMS].off;
    assign res.byte_off = stag_pkg::BYTE_W'(res.elem_off) << cfg.esl;

    stag_out_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (chain_valid[LP_DIMS] && en),
        .i_res   (res),
        .i_stall (i_stall),
        .o_ready (en),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_stall          = !en;
    assign o_element_offset = out_res.elem_off;
    assign o_byte_offset    = out_res.byte_off;
    assign o_out_of_range   = out_res.oor;
    assign o_is_dense       = out_res.dense;

    `STAG_ASSERT_NOW(a_oor_zero, i_clk, i_rst_n, o_valid && o_out_of_range, o_element_offset == '0)
    `STAG_ASSERT_NOW(a_byte_scale, i_clk, i_rst_n, o_valid, o_byte_offset == (stag_pkg::BYTE_W'(o_element_offset) << cfg.esl))
    `STAG_ASSERT_NEXT(a_stall_frees, i_clk, i_rst_n, o_stall && !i_stall, !o_stall)

endmodule

`default_nettype wire
